/* rtl/htbd_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman tree byte decoder package
// Sizes, codes and the result record shared by the decoder files.
// ----------------------------------------------------------------------------
package htbd_pkg;

	localparam int TREE_NODES  = 255;
	localparam int LENGTH_BITS = 20;

	localparam int NODE_W  = 8;
	localparam int CHILD_W = NODE_W + 1;
	localparam int ENTRY_W = 2 * CHILD_W;

	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(TREE_NODES - 1);

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_DATA  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_ERR,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_of_item;
		logic       chunk_done;
		logic       error;
	} result_t;

endpackage

/* rtl/htbd_in_if.sv */
// ----------------------------------------------------------------------------
// Decoder input channel
// Valid/ready channel that carries load, start and data transactions.
// ----------------------------------------------------------------------------
interface htbd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  node_index;
	logic [8:0]  child_zero;
	logic [8:0]  child_one;
	logic [19:0] chunk_length;
	logic [7:0]  data_byte;

	modport source (
		output valid, action, node_index, child_zero, child_one, chunk_length, data_byte,
		input  ready
	);
	modport sink (
		input  valid, action, node_index, child_zero, child_one, chunk_length, data_byte,
		output ready
	);
endinterface

/* rtl/htbd_out_if.sv */
// ----------------------------------------------------------------------------
// Decoder output channel
// Valid/ready channel that carries one decoded symbol or error per transaction.
// ----------------------------------------------------------------------------
interface htbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last_of_item;
	logic       chunk_done;
	logic       error;

	modport source (
		output valid, symbol, last_of_item, chunk_done, error,
		input  ready
	);
	modport sink (
		input  valid, symbol, last_of_item, chunk_done, error,
		output ready
	);
endinterface

/* rtl/htbd_out_stage.sv */
// ----------------------------------------------------------------------------
// Decoder output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module htbd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  htbd_pkg::result_t push_data,
	output logic              free,
	htbd_out_if.source        results
);
	import htbd_pkg::*;

	logic    valid_q;
	result_t data_q;

	// The slot can take a new result when it is empty or drains this cycle.
	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign results.valid        = valid_q;
	assign results.symbol       = data_q.symbol;
	assign results.last_of_item = data_q.last_of_item;
	assign results.chunk_done   = data_q.chunk_done;
	assign results.error        = data_q.error;

endmodule

/* rtl/huffman_tree_byte_decoder_top.sv */
// Load and start transactions are taken in ST_IDLE; a zero-length start also
// passes through ST_ERR. A data byte is accepted, walked in ST_STEP bit by bit
// and, when it decoded anything, its final result is released in ST_FLUSH.
// Each bit needs one dependent lookup in the single-port node table, so the
// walk runs at one bit per cycle unless an output stall holds it.
// Reset puts the walk at the root, stopped, with no pending result; the table is not cleared.
// ----------------------------------------------------------------------------
// Huffman tree byte decoder
// Walks a 255-node binary tree table held in a synchronous memory, one input
// bit per cycle unless output stalls, and emits one transaction per decoded symbol or error.
// ----------------------------------------------------------------------------
module huffman_tree_byte_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	htbd_in_if.sink    items,
	htbd_out_if.source results
);
	import htbd_pkg::*;

	state_t                 state_q, state_d;
	logic [NODE_W-1:0]      node_q;
	logic [LENGTH_BITS-1:0] left_q;
	logic                   stopped_q;
	logic [2:0]             bit_q;
	logic [7:0]             byte_q;
	logic                   pend_valid_q;
	result_t                pend_q;

	logic [ENTRY_W-1:0]     node_mem [TREE_NODES];
	logic [ENTRY_W-1:0]     rd_q;
	logic                   rd_en;
	logic [NODE_W-1:0]      rd_addr;
	logic                   wr_en;

	logic                   accept;
	action_t                act;
	logic [LENGTH_BITS-1:0] start_len;
	logic                   start_zero;
	logic [CHILD_W-1:0]     child;
	logic                   is_node;
	logic [NODE_W-1:0]      target;
	logic                   bad;
	logic [LENGTH_BITS-1:0] left_dec;
	logic                   done;
	logic                   finish;
	logic                   produce;
	result_t                res_new;
	logic                   out_free;
	logic                   stall;
	logic                   adv;
	logic                   push;
	result_t                push_data;

	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign act         = action_t'(items.action);
	assign start_len   = LENGTH_BITS'(items.chunk_length);
	assign start_zero  = (start_len == '0);

	// Child selected by the current bit of the byte from the node just read.
	assign child    = byte_q[bit_q] ? rd_q[ENTRY_W-1:CHILD_W] : rd_q[CHILD_W-1:0];
	assign is_node  = child[CHILD_W-1];
	assign target   = child[NODE_W-1:0];
	assign bad      = is_node && (target >= NODE_W'(TREE_NODES));
	assign left_dec = left_q - LENGTH_BITS'(1);
	assign done     = !is_node && (left_dec == '0);
	assign finish   = done || bad || (bit_q == 3'd7);
	assign produce  = (state_q == ST_STEP) && (!is_node || bad);

	always_comb begin
		res_new = '0;
		if (bad) begin
			res_new.error = 1'b1;
		end else begin
			res_new.symbol     = child[7:0];
			res_new.chunk_done = done;
		end
	end

	// The newest result is held back until the walk knows whether it is the
	// last one of the byte; a step that displaces it waits for the output slot.
	assign stall = produce && pend_valid_q && !out_free;
	assign adv   = (state_q == ST_STEP) && !stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && act == ACT_DATA && !stopped_q) begin
					state_d = ST_STEP;
				end else if (accept && act == ACT_START && start_zero) begin
					state_d = ST_ERR;
				end
			end
			ST_STEP: begin
				if (adv && finish) begin
					state_d = (produce || pend_valid_q) ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		push      = 1'b0;
		push_data = '0;
		rd_en     = 1'b0;
		rd_addr   = node_q;
		wr_en     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				wr_en   = accept && act == ACT_LOAD && (items.node_index < NODE_W'(TREE_NODES));
				rd_en   = accept && act == ACT_DATA && !stopped_q;
				rd_addr = node_q;
			end
			ST_STEP: begin
				push      = adv && produce && pend_valid_q;
				push_data = pend_q;
				rd_en     = adv && !finish;
				rd_addr   = is_node ? target : ROOT_NODE;
			end
			ST_ERR: begin
				push                   = out_free;
				push_data.error        = 1'b1;
				push_data.last_of_item = 1'b1;
			end
			ST_FLUSH: begin
				push                   = out_free;
				push_data              = pend_q;
				push_data.last_of_item = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			node_q    <= ROOT_NODE;
			left_q    <= '0;
			stopped_q <= 1'b1;
			bit_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept) begin
				if (act == ACT_START) begin
					node_q    <= ROOT_NODE;
					left_q    <= start_len;
					stopped_q <= start_zero;
				end else if (act == ACT_DATA && !stopped_q) begin
					bit_q <= '0;
				end
			end else if (adv) begin
				bit_q <= bit_q + 3'd1;
				if (bad) begin
					stopped_q <= 1'b1;
				end else if (is_node) begin
					node_q <= target;
				end else begin
					node_q <= ROOT_NODE;
					left_q <= left_dec;
					if (done) begin
						stopped_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (adv && produce) begin
			pend_valid_q <= 1'b1;
		end else if (state_q == ST_FLUSH && out_free) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			pend_q <= res_new;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && act == ACT_DATA) begin
			byte_q <= items.data_byte;
		end
	end

	// Node table: child_zero in the low half, child_one in the high half.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[items.node_index] <= {items.child_one, items.child_zero};
		end
		if (rd_en) begin
			rd_q <= node_mem[rd_addr];
		end
	end

	htbd_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.free      (out_free),
		.results   (results)
	);

`ifndef SYNTH
	a_push_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (state_q != ST_IDLE))
		else $error("result pushed while idle");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.chunk_done) |=> stopped_q)
		else $error("walk not stopped after chunk completion");

	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_addr < NODE_W'(TREE_NODES)))
		else $error("node table read beyond the table");

	a_last_bit_exits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && bit_q == 3'd7) |=> (state_q == ST_IDLE || state_q == ST_FLUSH))
		else $error("walk continued past the last bit of a byte");
`endif

endmodule

/* sim/huffman_tree_byte_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree byte decoder testbench
// Loads tree nodes, starts chunks and streams compressed bytes with random
// gaps on the input side and random stalls on the output side. Every decoded
// symbol is checked against a tree walk kept inside the testbench.
// ----------------------------------------------------------------------------
module huffman_tree_byte_decoder_top_tb;
	import htbd_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 85;
	localparam int TAIL_CYCLES  = 20;
	localparam int REPORT_LIMIT = 10;
	localparam int LEAF_LIMIT   = 256;
	localparam logic [8:0] BAD_CHILD     = 9'h1FF;
	localparam logic [7:0] OUT_OF_TABLE  = 8'hFF;
	localparam logic [1:0] ACT_UNUSED    = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  node_index;
		logic [8:0]  child_zero;
		logic [8:0]  child_one;
		logic [19:0] chunk_length;
		logic [7:0]  data_byte;
	} tree_item_t;

	logic clk;
	logic arst_n;

	htbd_in_if  item_bus ();
	htbd_out_if result_bus ();

	huffman_tree_byte_decoder_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_bus),
		.results (result_bus)
	);

	// Items waiting to be sent and symbols waiting to come out.
	tree_item_t pending_items[$];
	result_t    expected_symbols[$];

	// Tree walk state of the testbench.
	logic [17:0] tree_mem [TREE_NODES];
	logic [7:0]  walk_node     = ROOT_NODE;
	logic [19:0] symbols_to_go = '0;
	bit          halted        = 1'b1;

	// Nodes that the stimulus has written, so no walk reads an empty node.
	bit node_loaded [256];
	int loaded_nodes[$];

	tree_item_t accepted_item;
	result_t    seen_symbol;
	result_t    wanted_symbol;
	bit         item_taken = 1'b0;
	int         burst_left = 4;
	int         gap_left   = 0;
	int         ready_hold = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int         mismatch_count = 0;
	int         cycle_count    = 0;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	task automatic add_item(input logic [1:0] act, input logic [7:0] idx,
			input logic [8:0] c0, input logic [8:0] c1,
			input logic [19:0] len, input logic [7:0] data);
		pending_items.push_back(tree_item_t'{act, idx, c0, c1, len, data});
	endtask

	task automatic add_load(input logic [7:0] idx, input logic [8:0] c0, input logic [8:0] c1);
		add_item(ACT_LOAD, idx, c0, c1, 20'($urandom), 8'($urandom));
		if (idx < TREE_NODES && !node_loaded[idx]) begin
			node_loaded[idx] = 1'b1;
			loaded_nodes.push_back(idx);
		end
	endtask

	task automatic add_start(input logic [19:0] len);
		add_item(ACT_START, 8'($urandom), 9'($urandom), 9'($urandom), len, 8'($urandom));
	endtask

	task automatic add_data(input logic [7:0] data);
		add_item(ACT_DATA, 8'($urandom), 9'($urandom), 9'($urandom), 20'($urandom), data);
	endtask

	// Mostly leaves and links to nodes already written, now and then a broken link.
	function automatic logic [8:0] make_child();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50 || loaded_nodes.size() == 0)
			return 9'($urandom_range(0, 255));
		if (pick < 97)
			return 9'(LEAF_LIMIT + loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)]);
		return BAD_CHILD;
	endfunction

	task automatic predict_symbols(input tree_item_t it);
		result_t     produced [8];
		int          n_out;
		int          bit_pos;
		logic [17:0] entry;
		logic [8:0]  child;
		n_out = 0;
		if (it.action == ACT_LOAD) begin
			if (it.node_index < TREE_NODES)
				tree_mem[it.node_index] = {it.child_one, it.child_zero};
		end else if (it.action == ACT_START) begin
			walk_node = ROOT_NODE;
			symbols_to_go = it.chunk_length;
			halted = (it.chunk_length == 0);
			if (halted) begin
				produced[0] = '{8'h00, 1'b0, 1'b0, 1'b1};
				n_out = 1;
			end
		end else if (it.action == ACT_DATA) begin
			bit_pos = 0;
			while (!halted && bit_pos < 8) begin
				entry = tree_mem[walk_node];
				child = it.data_byte[bit_pos] ? entry[17:9] : entry[8:0];
				if (child < LEAF_LIMIT) begin
					symbols_to_go = symbols_to_go - 1'b1;
					walk_node = ROOT_NODE;
					halted = (symbols_to_go == 0);
					produced[n_out] = '{child[7:0], 1'b0, halted, 1'b0};
					n_out++;
				end else if (child - LEAF_LIMIT >= TREE_NODES) begin
					produced[n_out] = '{8'h00, 1'b0, 1'b0, 1'b1};
					n_out++;
					halted = 1'b1;
				end else begin
					walk_node = 8'(child - LEAF_LIMIT);
				end
				bit_pos++;
			end
		end
		if (n_out > 0)
			produced[n_out - 1].last_of_item = 1'b1;
		for (int k = 0; k < n_out; k++)
			expected_symbols.push_back(produced[k]);
	endtask

	task automatic log_mismatch(input string note, input result_t want, input result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch, %s: expected symbol %02h last %0b done %0b error %0b, %s",
				note, want.symbol, want.last_of_item, want.chunk_done, want.error,
				$sformatf("got symbol %02h last %0b done %0b error %0b",
				got.symbol, got.last_of_item, got.chunk_done, got.error));
	endtask

	// Input driver: bursts of transactions separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else if (!(item_bus.valid && !item_taken)) begin
			item_taken = 1'b0;
			if (gap_left > 0 || pending_items.size() == 0) begin
				item_bus.valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				item_bus.action       <= pending_items[0].action;
				item_bus.node_index   <= pending_items[0].node_index;
				item_bus.child_zero   <= pending_items[0].child_zero;
				item_bus.child_one    <= pending_items[0].child_one;
				item_bus.chunk_length <= pending_items[0].chunk_length;
				item_bus.data_byte    <= pending_items[0].data_byte;
				item_bus.valid        <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					if ($urandom_range(0, 4) == 0) begin
						burst_left = 30;
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 8);
						gap_left = $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Output stalls follow a rotating pattern that is replaced now and then.
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_hold = $urandom_range(16, 64);
			ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		end else begin
			ready_hold--;
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		end
		result_bus.ready <= ready_pattern[0];
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready) begin
				accepted_item = pending_items.pop_front();
				predict_symbols(accepted_item);
				item_taken = 1'b1;
			end
			if (result_bus.valid && result_bus.ready) begin
				seen_symbol = '{result_bus.symbol, result_bus.last_of_item,
					result_bus.chunk_done, result_bus.error};
				if (expected_symbols.size() == 0) begin
					log_mismatch("nothing expected", '0, seen_symbol);
				end else begin
					wanted_symbol = expected_symbols.pop_front();
					if (seen_symbol.symbol !== wanted_symbol.symbol ||
						seen_symbol.last_of_item !== wanted_symbol.last_of_item ||
						seen_symbol.chunk_done !== wanted_symbol.chunk_done ||
						seen_symbol.error !== wanted_symbol.error)
						log_mismatch("wrong field", wanted_symbol, seen_symbol);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("huffman_tree_byte_decoder_top verification failed");
			$finish;
		end
	end

	initial begin
		int          random_count;
		int          node_count;
		int          byte_count;
		int          pick;
		logic [19:0] len;
		random_count = 0;
		arst_n = 1'b0;
		item_bus.valid        = 1'b0;
		item_bus.action       = ACT_LOAD;
		item_bus.node_index   = '0;
		item_bus.child_zero   = '0;
		item_bus.child_one    = '0;
		item_bus.chunk_length = '0;
		item_bus.data_byte    = '0;
		result_bus.ready      = 1'b0;

		// Directed part. Bytes before any start and unknown actions are dropped.
		add_data(8'hA5);
		add_item(ACT_UNUSED, 8'h12, 9'h034, 9'h056, 20'h00007, 8'h3C);
		add_load(ROOT_NODE, 9'h000, 9'h0FF);
		add_load(8'h00, 9'h0FF, 9'(LEAF_LIMIT + ROOT_NODE));
		// Root: a 0 bit goes to node 0, a 1 bit gives 5A.
		add_load(ROOT_NODE, 9'(LEAF_LIMIT + 0), 9'h05A);
		// A load past the end of the table is ignored.
		add_item(ACT_LOAD, OUT_OF_TABLE, 9'h000, BAD_CHILD, 20'hFFFFF, 8'hFF);
		add_start(20'h00000);
		add_data(8'h00);
		add_start(20'd3);
		add_data(8'hFF);
		add_data(8'h00);
		add_start(20'hFFFFF);
		add_data(8'hFF);
		// The last bit leaves the walk at node 0, finished by the next byte.
		add_data(8'h7F);
		add_data(8'h00);
		add_data(8'hAA);
		add_load(8'h01, BAD_CHILD, 9'h080);
		add_load(ROOT_NODE, 9'(LEAF_LIMIT + 1), 9'(LEAF_LIMIT + 0));
		add_start(20'd2);
		add_data(8'h00);
		add_start(20'd1);
		add_data(8'h02);

		// Random part: a few fresh nodes, a new root, a start and a run of bytes.
		while (random_count < RANDOM_ITEMS) begin
			node_count = $urandom_range(1, 4);
			repeat (node_count) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					add_item(ACT_LOAD, OUT_OF_TABLE, 9'($urandom), 9'($urandom),
						20'($urandom), 8'($urandom));
				end else begin
					add_load((pick == 1) ? ROOT_NODE : 8'($urandom_range(0, TREE_NODES - 2)),
						make_child(), make_child());
					random_count++;
				end
			end
			add_load(ROOT_NODE, make_child(), make_child());
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = '0;
			else if (pick < 3)
				len = 20'($urandom);
			else
				len = 20'($urandom_range(1, 12));
			add_start(len);
			random_count += 2;
			byte_count = $urandom_range(1, 8);
			repeat (byte_count) begin
				if ($urandom_range(0, 15) == 0) begin
					add_item(ACT_UNUSED, 8'($urandom), 9'($urandom), 9'($urandom),
						20'($urandom), 8'($urandom));
				end else begin
					add_data(8'($urandom));
					random_count++;
				end
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || expected_symbols.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_symbols.size() == 0)
			$display("huffman_tree_byte_decoder_top verification clean");
		else
			$display("huffman_tree_byte_decoder_top verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/htbd_pkg.sv
rtl/htbd_in_if.sv
rtl/htbd_out_if.sv
rtl/htbd_out_stage.sv
rtl/huffman_tree_byte_decoder_top.sv
sim/huffman_tree_byte_decoder_top_tb.sv
